### src/hbsld_pkg.sv
// shared constants and types for the bit string literal decoder
`default_nettype none

package hbsld_pkg;

  localparam int unsigned DATA_W    = 64;
  localparam int unsigned WIDTH_W   = 7;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned ERR_W     = 3;
  localparam int unsigned MAX_WIDTH = 64;

  localparam logic [ERR_W-1:0] ERR_OK        = 3'd0;
  localparam logic [ERR_W-1:0] ERR_DIGIT     = 3'd1;
  localparam logic [ERR_W-1:0] ERR_DEC       = 3'd2;
  localparam logic [ERR_W-1:0] ERR_WIDE      = 3'd3;
  localparam logic [ERR_W-1:0] ERR_MALFORMED = 3'd4;

  // token state after the current character, as seen by the result logic
  typedef struct packed {
    logic                char_lit;
    logic                size_given;
    logic [7:0]          explicit_size;
    logic                base_dec;
    logic [7:0]          bit_count;
    logic [WIDTH_W-1:0]  dec_width;
    logic [DATA_W-1:0]   value;
    logic [DATA_W-1:0]   mask;
    logic [KIND_W-1:0]   kind;
    logic [ERR_W-1:0]    err;
  } emit_info_t;

endpackage

`default_nettype wire

### src/hbsld_parser.sv
// per-character token parser with accumulators and phase tracking
`default_nettype none

module hbsld_parser (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  logic [7:0]             char_i,
  input  logic                   last_i,
  output hbsld_pkg::emit_info_t  info_o
);
  import hbsld_pkg::*;

  typedef enum logic [2:0] {
    PH_START     = 3'd0,
    PH_SIZE      = 3'd1,
    PH_TYPED     = 3'd2,
    PH_BASED     = 3'd3,
    PH_DIGITS    = 3'd4,
    PH_CHAR_OPEN = 3'd5,
    PH_CHAR_HAVE = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    BASE_BIN = 2'd0,
    BASE_OCT = 2'd1,
    BASE_HEX = 2'd2,
    BASE_DEC = 2'd3
  } base_e;

  localparam logic [KIND_W-1:0] KIND_SLV      = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SIGNED   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_UNSIGNED = 2'd2;
  localparam logic [KIND_W-1:0] KIND_BIT      = 2'd3;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_APOS  = 8'h27;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_B     = 8'h42;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_F     = 8'h46;
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_U     = 8'h55;
  localparam logic [7:0] CH_X     = 8'h58;
  localparam logic [7:0] CH_Z     = 8'h5A;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;

  localparam logic [DATA_W-1:0] DEC_LIMIT = 64'h1999_9999_9999_9999;

  phase_e              ph_q, ph_d, cur_ph;
  base_e               base_q, base_d;
  logic [7:0]          size_q, size_d;
  logic                given_q, given_d;
  logic [KIND_W-1:0]   kind_q, kind_d;
  logic [DATA_W-1:0]   val_q, val_d;
  logic [DATA_W-1:0]   mask_q, mask_d;
  logic [7:0]          bc_q, bc_d;
  logic [ERR_W-1:0]    err_q, err_d;

  logic [7:0]          u;
  logic                is_dig;
  logic [3:0]          dig_val;
  logic [3:0]          hex_val;
  logic [3:0]          lim;
  logic [DATA_W-1:0]   full;
  logic [DATA_W-1:0]   val_shift;
  logic [DATA_W-1:0]   mask_shift;
  logic [8:0]          bc_sum;
  logic [7:0]          bc_sat;
  logic [11:0]         size_ext;
  logic [7:0]          size_sat;
  logic                dec_over;
  logic [DATA_W-1:0]   mul10;
  logic [2:0]          hb;
  logic [2:0]          hj;
  logic [7:0]          top_byte;
  logic [WIDTH_W-1:0]  dec_width;

  function automatic logic [ERR_W-1:0] raise_err(input logic [ERR_W-1:0] cur,
                                                 input logic [ERR_W-1:0] code);
    if (code == ERR_MALFORMED) begin
      return ERR_MALFORMED;
    end else if (cur == ERR_OK) begin
      return code;
    end else begin
      return cur;
    end
  endfunction

  assign u       = (char_i >= CH_LA && char_i <= CH_LZ) ? char_i - 8'd32 : char_i;
  assign is_dig  = (u >= CH_0) && (u <= CH_9);
  assign dig_val = 4'(u - CH_0);
  assign hex_val = 4'(u - CH_A + 8'd10);
  assign lim     = (base_q == BASE_BIN) ? 4'd1 : 4'd7;

  always_comb begin
    case (base_q)
      BASE_BIN: begin
        val_shift  = val_q << 1;
        mask_shift = mask_q << 1;
        full       = 64'h1;
        bc_sum     = {1'b0, bc_q} + 9'd1;
      end
      BASE_OCT: begin
        val_shift  = val_q << 3;
        mask_shift = mask_q << 3;
        full       = 64'h7;
        bc_sum     = {1'b0, bc_q} + 9'd3;
      end
      default: begin
        val_shift  = val_q << 4;
        mask_shift = mask_q << 4;
        full       = 64'hF;
        bc_sum     = {1'b0, bc_q} + 9'd4;
      end
    endcase
  end

  assign bc_sat   = bc_sum[8] ? 8'hFF : bc_sum[7:0];
  assign size_ext = ({4'b0, size_q} << 3) + ({4'b0, size_q} << 1) + {8'b0, dig_val};
  assign size_sat = (size_ext > 12'd255) ? 8'hFF : size_ext[7:0];
  assign dec_over = (val_q > DEC_LIMIT) || ((val_q == DEC_LIMIT) && (dig_val > 4'd5));
  assign mul10    = (val_q << 3) + (val_q << 1) + {60'b0, dig_val};
  assign cur_ph   = (ph_q == PH_SIZE || ph_q == PH_TYPED) ? ph_q : PH_START;

  // highest set bit of the decimal accumulator, byte first then bit
  always_comb begin
    hb = 3'd0;
    for (int b = 0; b < 8; b++) begin
      if (|val_q[b*8 +: 8]) hb = 3'(b);
    end
    top_byte = val_q[{hb, 3'b000} +: 8];
    hj = 3'd0;
    for (int j = 0; j < 8; j++) begin
      if (top_byte[j]) hj = 3'(j);
    end
    dec_width = (val_q == '0) ? 7'd1 : {1'b0, hb, hj} + 7'd1;
  end

  always_comb begin
    ph_d    = ph_q;
    base_d  = base_q;
    size_d  = size_q;
    given_d = given_q;
    kind_d  = kind_q;
    val_d   = val_q;
    mask_d  = mask_q;
    bc_d    = bc_q;
    err_d   = err_q;
    unique case (ph_q)
      PH_DIGITS: begin
        if (!last_i && u != CH_UNDER) begin
          if (base_q == BASE_DEC) begin
            if (!is_dig) begin
              err_d = raise_err(err_q, ERR_DEC);
            end else if (dec_over) begin
              val_d = '1;
              err_d = raise_err(err_q, ERR_WIDE);
            end else begin
              val_d = mul10;
            end
          end else begin
            val_d  = val_shift;
            mask_d = mask_shift;
            bc_d   = bc_sat;
            if (u == CH_X) begin
              mask_d = mask_shift | full;
            end else if (u == CH_Z) begin
              val_d  = val_shift | full;
              mask_d = mask_shift | full;
            end else if (u == CH_0 || u == CH_DASH) begin
              val_d = val_shift;
            end else if (is_dig && (base_q == BASE_HEX || dig_val <= lim)) begin
              val_d = val_shift | {60'b0, dig_val};
            end else if (base_q == BASE_HEX && u >= CH_A && u <= CH_F) begin
              val_d = val_shift | {60'b0, hex_val};
            end else begin
              err_d = raise_err(err_q, ERR_DIGIT);
            end
          end
        end
      end
      PH_CHAR_OPEN: begin
        val_d  = {63'b0, (u == CH_1) || (u == CH_Z)};
        mask_d = {63'b0, (u == CH_X) || (u == CH_Z)};
        kind_d = KIND_BIT;
        ph_d   = PH_CHAR_HAVE;
      end
      PH_CHAR_HAVE: begin
        ph_d = ph_q;
      end
      PH_BASED: begin
        if (u == CH_QUOTE) begin
          ph_d = PH_DIGITS;
        end else begin
          err_d = ERR_MALFORMED;
        end
        if (last_i) err_d = ERR_MALFORMED;
      end
      default: begin
        if (cur_ph == PH_START && char_i == CH_APOS) begin
          ph_d = PH_CHAR_OPEN;
          if (last_i) err_d = ERR_MALFORMED;
        end else begin
          ph_d = cur_ph;
          if (cur_ph != PH_TYPED && is_dig) begin
            size_d  = size_sat;
            given_d = 1'b1;
            ph_d    = PH_SIZE;
          end else if (cur_ph != PH_TYPED && (u == CH_S || u == CH_U)) begin
            kind_d = (u == CH_S) ? KIND_SIGNED : KIND_UNSIGNED;
            ph_d   = PH_TYPED;
          end else if (u == CH_QUOTE) begin
            ph_d = PH_DIGITS;
          end else begin
            ph_d = PH_BASED;
            if (u == CH_B) begin
              base_d = BASE_BIN;
            end else if (u == CH_O) begin
              base_d = BASE_OCT;
            end else if (u == CH_X) begin
              base_d = BASE_HEX;
            end else if (u == CH_D) begin
              base_d = BASE_DEC;
            end else begin
              err_d = ERR_MALFORMED;
            end
          end
          if (last_i) err_d = ERR_MALFORMED;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q    <= PH_START;
      base_q  <= BASE_BIN;
      size_q  <= '0;
      given_q <= 1'b0;
      kind_q  <= KIND_SLV;
      val_q   <= '0;
      mask_q  <= '0;
      bc_q    <= '0;
      err_q   <= ERR_OK;
    end else if (step_i) begin
      if (last_i) begin
        ph_q    <= PH_START;
        base_q  <= BASE_BIN;
        size_q  <= '0;
        given_q <= 1'b0;
        kind_q  <= KIND_SLV;
        val_q   <= '0;
        mask_q  <= '0;
        bc_q    <= '0;
        err_q   <= ERR_OK;
      end else begin
        ph_q    <= ph_d;
        base_q  <= base_d;
        size_q  <= size_d;
        given_q <= given_d;
        kind_q  <= kind_d;
        val_q   <= val_d;
        mask_q  <= mask_d;
        bc_q    <= bc_d;
        err_q   <= err_d;
      end
    end
  end

  assign info_o.char_lit      = (ph_d == PH_CHAR_HAVE);
  assign info_o.size_given    = given_d;
  assign info_o.explicit_size = size_d;
  assign info_o.base_dec      = (base_d == BASE_DEC);
  assign info_o.bit_count     = bc_d;
  assign info_o.dec_width     = dec_width;
  assign info_o.value         = val_d;
  assign info_o.mask          = mask_d;
  assign info_o.kind          = kind_d;
  assign info_o.err           = err_d;

endmodule

`default_nettype wire

### src/hdl_bit_string_literal_decoder_unit.sv
// top level of the bit string literal decoder: input register, parser, result register
// one character per cycle sustained; a last character waits in the input register while
// an earlier result is not taken; a character is consumed from the input register into the
// parser state, and the result of a token is registered in the result register when its
// last character leaves the input register; width, cut and error are set combinationally
// reset clears the input and result valid flags and returns the parser to start of token
`default_nettype none

module hdl_bit_string_literal_decoder_unit #(
  parameter int unsigned MAX_WIDTH = hbsld_pkg::MAX_WIDTH
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // character_code
  input  logic         s_axis_tlast,   // last_char
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [143:0] m_axis_tdata,   // literal_value, unknown_mask, literal_width,
                                       // error_code, zero pad
  output logic [1:0]   m_axis_tuser    // literal_kind
);
  import hbsld_pkg::*;

  logic               in_valid_q, in_valid_d;
  logic [7:0]         in_char_q;
  logic               in_last_q;
  logic               out_free;
  logic               consume;
  logic               in_take;

  emit_info_t         info;

  logic [7:0]         width_raw;
  logic               too_wide;
  logic [WIDTH_W-1:0] width_cut;
  logic [DATA_W-1:0]  cut_mask;

  logic               out_valid_q, out_valid_d;
  logic [DATA_W-1:0]  res_value_q, res_value_d;
  logic [DATA_W-1:0]  res_mask_q, res_mask_d;
  logic [WIDTH_W-1:0] res_width_q, res_width_d;
  logic [KIND_W-1:0]  res_kind_q, res_kind_d;
  logic [ERR_W-1:0]   res_err_q, res_err_d;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign consume       = in_valid_q && (!in_last_q || out_free);
  assign s_axis_tready = !in_valid_q || consume;
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign in_valid_d    = in_take ? 1'b1 : (consume ? 1'b0 : in_valid_q);

  hbsld_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (consume),
    .char_i (in_char_q),
    .last_i (in_last_q),
    .info_o (info)
  );

  always_comb begin
    if (info.char_lit) begin
      width_raw = 8'd1;
    end else if (info.size_given) begin
      width_raw = info.explicit_size;
    end else if (info.base_dec) begin
      width_raw = {1'b0, info.dec_width};
    end else begin
      width_raw = info.bit_count;
    end
    too_wide  = width_raw > 8'(MAX_WIDTH);
    width_cut = too_wide ? WIDTH_W'(MAX_WIDTH) : width_raw[WIDTH_W-1:0];
    cut_mask  = (width_cut >= 7'(DATA_W)) ? '1 : ((64'd1 << width_cut) - 64'd1);

    if (info.err == ERR_MALFORMED) begin
      res_value_d = '0;
      res_mask_d  = '0;
      res_width_d = '0;
      res_kind_d  = '0;
      res_err_d   = ERR_MALFORMED;
    end else begin
      res_value_d = info.value & cut_mask;
      res_mask_d  = info.mask & cut_mask;
      res_width_d = width_cut;
      res_kind_d  = info.kind;
      res_err_d   = (too_wide && info.err == ERR_OK) ? ERR_WIDE : info.err;
    end
  end

  assign out_valid_d = (consume && in_last_q) ? 1'b1
                     : (m_axis_tready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_char_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
    if (consume && in_last_q) begin
      res_value_q <= res_value_d;
      res_mask_q  <= res_mask_d;
      res_width_q <= res_width_d;
      res_kind_q  <= res_kind_d;
      res_err_q   <= res_err_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, res_err_q, res_width_q, res_mask_q, res_value_q};
  assign m_axis_tuser  = res_kind_q;

endmodule

`default_nettype wire

### verif/tb_top.sv
// self-checking testbench for the bit string literal decoder: directed and random tokens
`default_nettype none

module tb_top;
  import hbsld_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned DRAIN_CYCLES   = 16;
  localparam int unsigned IDLE_PCT       = 19;
  localparam int unsigned RANDOM_ITEMS   = 690;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_TICK  = 8'h27;

  localparam logic [KIND_W-1:0] KIND_VECTOR   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SIGNED   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_UNSIGNED = 2'd2;
  localparam logic [KIND_W-1:0] KIND_BIT      = 2'd3;

  typedef enum logic [2:0] {
    SCAN_IDLE, SCAN_SIZE, SCAN_SIGN, SCAN_RADIX, SCAN_BODY, SCAN_TICK, SCAN_TICK_DONE
  } scan_e;

  typedef enum logic [1:0] {RADIX_2, RADIX_8, RADIX_16, RADIX_10} radix_e;

  typedef struct packed {
    logic [ERR_W-1:0]   err;
    logic [KIND_W-1:0]  kind;
    logic [WIDTH_W-1:0] width;
    logic [DATA_W-1:0]  mask;
    logic [DATA_W-1:0]  value;
  } literal_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = 8'h00;
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [143:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;

  hdl_bit_string_literal_decoder_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),  // character_code
    .s_axis_tlast  (s_axis_tlast),  // last_char
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),  // literal_value, unknown_mask, literal_width,
                                    // error_code, zero pad
    .m_axis_tuser  (m_axis_tuser)   // literal_kind
  );

  always #4 clk_i = ~clk_i;

  // decoder state mirror
  scan_e              scan;
  logic [7:0]         size_val;
  logic               size_seen;
  logic [KIND_W-1:0]  kind_q;
  radix_e             radix;
  logic [DATA_W-1:0]  acc_val;
  logic [DATA_W-1:0]  acc_unk;
  logic [7:0]         nbits;
  logic [ERR_W-1:0]   err_q;

  literal_t    literal_expected[$];
  logic [7:0]  token_buf[$];
  int unsigned chars_sent = 0;
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles = 0;
  logic        quiet = 1'b0;
  literal_t    got_lit;
  literal_t    want_lit;

  function automatic void clear_token();
    scan      = SCAN_IDLE;
    size_val  = 8'd0;
    size_seen = 1'b0;
    kind_q    = KIND_VECTOR;
    radix     = RADIX_2;
    acc_val   = '0;
    acc_unk   = '0;
    nbits     = 8'd0;
    err_q     = ERR_OK;
  endfunction

  function automatic void queue_char(logic [7:0] c);
    token_buf = {token_buf, c};
  endfunction

  function automatic logic is_num(logic [7:0] u);
    return u >= "0" && u <= "9";
  endfunction

  function automatic void flag_error(logic [ERR_W-1:0] code);
    if (code == ERR_MALFORMED) err_q = ERR_MALFORMED;
    else if (err_q == ERR_OK) err_q = code;
  endfunction

  function automatic void radix_or_quote(logic [7:0] u);
    if (u == CH_QUOTE) begin
      scan = SCAN_BODY;
    end else begin
      scan = SCAN_RADIX;
      if (u == "B") radix = RADIX_2;
      else if (u == "O") radix = RADIX_8;
      else if (u == "X") radix = RADIX_16;
      else if (u == "D") radix = RADIX_10;
      else flag_error(ERR_MALFORMED);
    end
  endfunction

  function automatic void body_char(logic [7:0] u);
    int unsigned       step;
    logic [DATA_W-1:0] fill;
    int unsigned       top;
    logic [DATA_W-1:0] d;
    if (u == "_") return;
    if (radix == RADIX_10) begin
      if (!is_num(u)) begin
        flag_error(ERR_DEC);
        return;
      end
      d = DATA_W'(u - "0");
      if (acc_val > 64'h1999999999999999 || (acc_val == 64'h1999999999999999 && d > 5)) begin
        acc_val = '1;
        flag_error(ERR_WIDE);
      end else begin
        acc_val = acc_val * 10 + d;
      end
      return;
    end
    step = (radix == RADIX_2) ? 1 : (radix == RADIX_8) ? 3 : 4;
    fill = (64'd1 << step) - 64'd1;
    top  = (radix == RADIX_2) ? 1 : 7;
    acc_val = acc_val << step;
    acc_unk = acc_unk << step;
    nbits   = (nbits + step > 255) ? 8'd255 : 8'(nbits + step);
    if (u == "X") begin
      acc_unk = acc_unk | fill;
    end else if (u == "Z") begin
      acc_val = acc_val | fill;
      acc_unk = acc_unk | fill;
    end else if (u == "0" || u == "-") begin
    end else if (is_num(u) && (radix == RADIX_16 || (u - "0") <= top)) begin
      acc_val = acc_val | DATA_W'(u - "0");
    end else if (radix == RADIX_16 && u >= "A" && u <= "F") begin
      acc_val = acc_val | DATA_W'(u - "A" + 10);
    end else begin
      flag_error(ERR_DIGIT);
    end
  endfunction

  function automatic void finish_token();
    literal_t          r;
    int unsigned       w;
    logic [DATA_W-1:0] cut;
    r = '0;
    if (err_q == ERR_MALFORMED) begin
      r.err = ERR_MALFORMED;
    end else begin
      if (scan == SCAN_TICK_DONE) begin
        w = 1;
      end else if (size_seen) begin
        w = size_val;
      end else if (radix == RADIX_10) begin
        w = 1;
        for (int i = 0; i < DATA_W; i++)
          if (acc_val[i]) w = i + 1;
      end else begin
        w = nbits;
      end
      if (w > MAX_WIDTH) begin
        flag_error(ERR_WIDE);
        w = MAX_WIDTH;
      end
      cut     = (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
      r.value = acc_val & cut;
      r.mask  = acc_unk & cut;
      r.width = WIDTH_W'(w);
      r.kind  = kind_q;
      r.err   = err_q;
    end
    literal_expected = {literal_expected, r};
    clear_token();
  endfunction

  function automatic void decode_char(logic [7:0] c, logic last);
    logic [7:0]  u;
    logic        done;
    int unsigned n;
    u    = (c >= "a" && c <= "z") ? c - 8'd32 : c;
    done = 1'b0;
    case (scan)
      SCAN_BODY: if (!last) body_char(u);
      SCAN_TICK: begin
        acc_val = (u == "1" || u == "Z") ? 64'd1 : 64'd0;
        acc_unk = (u == "X" || u == "Z") ? 64'd1 : 64'd0;
        kind_q  = KIND_BIT;
        scan    = SCAN_TICK_DONE;
      end
      SCAN_TICK_DONE: ;
      SCAN_RADIX: begin
        if (u == CH_QUOTE) scan = SCAN_BODY;
        else flag_error(ERR_MALFORMED);
        if (last) flag_error(ERR_MALFORMED);
      end
      default: begin
        if (scan != SCAN_SIGN && scan != SCAN_SIZE) begin
          scan = SCAN_IDLE;
          if (c == CH_TICK) begin
            scan = SCAN_TICK;
            if (last) flag_error(ERR_MALFORMED);
            done = 1'b1;
          end
        end
        if (!done) begin
          if (scan != SCAN_SIGN && is_num(u)) begin
            n         = size_val * 10 + (u - "0");
            size_val  = (n > 255) ? 8'd255 : 8'(n);
            size_seen = 1'b1;
            scan      = SCAN_SIZE;
          end else if (scan != SCAN_SIGN && (u == "S" || u == "U")) begin
            kind_q = (u == "S") ? KIND_SIGNED : KIND_UNSIGNED;
            scan   = SCAN_SIGN;
          end else begin
            radix_or_quote(u);
          end
          if (last) flag_error(ERR_MALFORMED);
        end
      end
    endcase
    if (last) finish_token();
  endfunction

  task automatic send_char(logic [7:0] c, logic last);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    chars_sent++;
    decode_char(c, last);
  endtask

  task automatic send_bytes();
    for (int i = 0; i < token_buf.size(); i++)
      send_char(token_buf[i], i == token_buf.size() - 1);
    token_buf.delete();
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) queue_char(s[i]);
    send_bytes();
  endtask

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) queue_char(s[i]);
  endfunction

  function automatic void put_pick(string s);
    queue_char(s[$urandom_range(s.len() - 1)]);
  endfunction

  task automatic test_radix_literals();
    send_text("B\"1010\"");
    send_text("x\"DEAD_beef\"");
    send_text("\"10XZ-\"");
    send_text("12uX\"fFf\"");
    send_text("8sx\"FF\"");
    send_text("o\"0777777777777777777777\"");
    send_text("300X\"1\"");
    send_text("X\"0123456789ABCDEF0\"");
    send_text("B\"\"");
    send_text("0B\"1\"");
  endtask

  task automatic test_decimal_literals();
    send_text("D\"255\"");
    send_text("D\"18446744073709551615\"");
    send_text("D\"18446744073709551616\"");
    send_text("d\"1a\"");
    send_text("D\"\"");
  endtask

  task automatic test_digit_errors();
    send_text("B\"102\"");
    send_text("O\"8\"");
    send_text("X\"G\"");
    put_text("B\"");
    queue_char(8'h00);
    queue_char(8'hFF);
    queue_char(CH_QUOTE);
    send_bytes();
  endtask

  task automatic test_char_literals();
    send_text("'1");
    send_text("'z");
    send_text("'Q'");
    send_text("'");
  endtask

  task automatic test_malformed_tokens();
    send_text("Q\"1\"");
    send_text("XY\"1\"");
    send_text("12");
    send_text("B\"");
  endtask

  function automatic void build_random_token();
    int unsigned r;
    int unsigned ndig;
    int unsigned b;
    string       digits;
    r = $urandom_range(99);
    if (r < 8) begin
      queue_char(CH_TICK);
      if ($urandom_range(3) == 0) queue_char(8'($urandom_range(255)));
      else put_pick("01xXzZ-QL");
      repeat ($urandom_range(2)) queue_char(8'($urandom_range(255)));
    end else if (r < 16) begin
      repeat ($urandom_range(1, 6)) queue_char(8'($urandom_range(255)));
    end else begin
      if ($urandom_range(9) < 6) begin
        if ($urandom_range(9) == 0) put_text($sformatf("%0d", $urandom_range(999)));
        else put_text($sformatf("%0d", $urandom_range(70)));
      end
      if ($urandom_range(3) == 0) put_pick("sSuU");
      b = $urandom_range(4);
      case (b)
        0: put_pick("bB");
        1: put_pick("oO");
        2: put_pick("xX");
        3: put_pick("dD");
        default: ;
      endcase
      if ($urandom_range(29) == 0) put_pick("QgY1s");
      if ($urandom_range(29) == 0) return;
      queue_char(CH_QUOTE);
      case (b)
        1: digits = "01234567xXzZ-_";
        2: digits = "0123456789abcdefABCDEFxXzZ-_";
        3: digits = "0123456789_";
        default: digits = "01xXzZ-_";
      endcase
      ndig = ($urandom_range(7) == 0) ? $urandom_range(30) : $urandom_range(12);
      repeat (ndig) begin
        if ($urandom_range(19) == 0) queue_char(8'($urandom_range(255)));
        else put_pick(digits);
      end
      if ($urandom_range(9) == 0) queue_char(8'($urandom_range(255)));
      else queue_char(CH_QUOTE);
    end
  endfunction

  task automatic test_random_tokens();
    int unsigned start;
    start = chars_sent;
    while (chars_sent - start < RANDOM_ITEMS) begin
      quiet = (chars_sent - start >= 300) && (chars_sent - start < 450);
      build_random_token();
      send_bytes();
    end
    quiet = 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      got_lit.value = m_axis_tdata[63:0];
      got_lit.mask  = m_axis_tdata[127:64];
      got_lit.width = m_axis_tdata[134:128];
      got_lit.err   = m_axis_tdata[137:135];
      got_lit.kind  = m_axis_tuser;
      if (literal_expected.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected transaction: value %h mask %h width %0d kind %0d err %0d",
                   got_lit.value, got_lit.mask, got_lit.width, got_lit.kind, got_lit.err);
      end else begin
        want_lit = literal_expected.pop_front();
        if (got_lit.value !== want_lit.value || got_lit.mask !== want_lit.mask ||
            got_lit.width !== want_lit.width || got_lit.kind !== want_lit.kind ||
            got_lit.err !== want_lit.err) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch exp: value %h mask %h width %0d kind %0d err %0d",
                     want_lit.value, want_lit.mask, want_lit.width, want_lit.kind,
                     want_lit.err);
            $display("         got: value %h mask %h width %0d kind %0d err %0d",
                     got_lit.value, got_lit.mask, got_lit.width, got_lit.kind, got_lit.err);
          end
        end
      end
    end
    m_axis_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
  end

  // watchdog on stalled handshakes
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    clear_token();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_radix_literals();
    test_decimal_literals();
    test_digit_errors();
    test_char_literals();
    test_malformed_tokens();
    test_random_tokens();
    s_axis_tvalid <= 1'b0;
    while (literal_expected.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && literal_expected.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
